[design/twok_pkg.sv]
// shared types, constants and helpers for the three-wheel omni kinematics core
// no dependencies; every other file of the block uses this package

package twok_pkg;

  localparam int FRAC_BITS = 16;
  localparam int K_SHIFT   = 30;
  localparam int LANES     = 3;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = VAL_W + 3;
  localparam int MAG_W     = VAL_W + 2;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = MAG_W + COEF_W;
  localparam int RES_W     = PROD_W + 2;
  localparam int DIST_W    = 24;
  localparam int MAP_W     = 6;
  localparam int IDX_W     = 3;

  localparam logic [COEF_W-1:0] K_INV3       = 32'd357913941;
  localparam logic [COEF_W-1:0] K_INV_SQRT3  = 32'd619925131;
  localparam logic [COEF_W-1:0] K_SQRT3_HALF = 32'd929887697;
  localparam logic [COEF_W-1:0] K_HALF       = 32'd536870912;

  localparam logic [1:0] MOTOR_NONE = 2'd3;

  localparam logic signed [RES_W-1:0] CLIP_MAX =
    {{(RES_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] CLIP_MIN =
    {{(RES_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    CFG_LAYOUT     = 3'd0,
    CFG_DISTANCE   = 3'd1,
    CFG_ROT_GAIN   = 3'd2,
    CFG_RPM_TO_VEL = 3'd3,
    CFG_VEL_TO_RPM = 3'd4,
    CFG_SLOT_MAP   = 3'd5,
    CFG_SIGN_MASK  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_FORWARD = 1'b0,
    REQ_INVERSE = 1'b1
  } req_e;

  typedef struct packed {
    logic                layout_reversed;
    logic [DIST_W-1:0]   wheel_distance;
    logic [COEF_W-1:0]   rotation_gain;
    logic [COEF_W-1:0]   rpm_to_velocity;
    logic [COEF_W-1:0]   velocity_to_rpm;
    logic [MAP_W-1:0]    motor_slot_map;
    logic [LANES-1:0]    motor_sign_mask;
  } cfg_t;

  typedef struct packed {
    req_e                    req;
    logic                    sat;
    logic signed [VAL_W-1:0] vy;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [COEF_W-1:0] coef;
    logic              neg;
    logic              long_shift;
  } lane_op_t;

  typedef lane_op_t [LANES-1:0] lane_ops_t;
  typedef logic [LANES-1:0][RES_W-1:0] res_vec_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    sat;
  } clip_t;

  function automatic clip_t clip32(logic signed [RES_W-1:0] v);
    clip_t c;
    c.sat = 1'b1;
    if (v > CLIP_MAX) begin
      c.val = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < CLIP_MIN) begin
      c.val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      c.val = v[VAL_W-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  function automatic logic signed [SUM_W-1:0] sext_val(logic signed [VAL_W-1:0] v);
    return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [RES_W-1:0] sext_sum(logic signed [SUM_W-1:0] v);
    return {{(RES_W-SUM_W){v[SUM_W-1]}}, v};
  endfunction

  function automatic logic [MAG_W-1:0] abs_mag(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] m;
    m = v[SUM_W-1] ? (~v + 1'b1) : v;
    return m[MAG_W-1:0];
  endfunction

  function automatic logic [1:0] slot_motor(logic [MAP_W-1:0] map, int k);
    return map[2*k +: 2];
  endfunction

endpackage

[design/twok_front.sv]
// operand preparation stage: slot mapping, motor signs and first-layer coefficients
// depends on twok_pkg

module twok_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_a_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_b_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_c_i,
  input  twok_pkg::cfg_t                 cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output twok_pkg::lane_ops_t            ops_o,
  output twok_pkg::side_t                side_o
);

  logic                valid_q;
  twok_pkg::lane_ops_t ops_d, ops_q;
  twok_pkg::side_t     side_d, side_q;
  logic signed [twok_pkg::VAL_W-1:0] v [twok_pkg::LANES];
  logic signed [twok_pkg::VAL_W-1:0] s;
  logic [1:0]          mot;
  logic                flip;

  assign v[0] = in_a_i;
  assign v[1] = in_b_i;
  assign v[2] = in_c_i;

  always_comb begin
    ops_d       = '0;
    s           = '0;
    mot         = twok_pkg::MOTOR_NONE;
    flip        = 1'b0;
    side_d.req  = twok_pkg::req_e'(req_type_i);
    side_d.sat  = 1'b0;
    side_d.vy   = in_b_i;
    if (side_d.req == twok_pkg::REQ_INVERSE) begin
      for (int k = 0; k < twok_pkg::LANES; k++) begin
        ops_d[k].mag = twok_pkg::abs_mag(twok_pkg::sext_val(v[k]));
        ops_d[k].neg = v[k][twok_pkg::VAL_W-1];
      end
      ops_d[0].coef       = twok_pkg::K_SQRT3_HALF;
      ops_d[0].long_shift = 1'b1;
      ops_d[1].coef       = twok_pkg::K_HALF;
      ops_d[1].long_shift = 1'b1;
      ops_d[2].coef       = {{(twok_pkg::COEF_W-twok_pkg::DIST_W){1'b0}},
                             cfg_i.wheel_distance};
      ops_d[2].long_shift = 1'b0;
    end else begin
      for (int k = 0; k < twok_pkg::LANES; k++) begin
        mot  = twok_pkg::slot_motor(cfg_i.motor_slot_map, k);
        s    = '0;
        flip = 1'b0;
        if (mot != twok_pkg::MOTOR_NONE) begin
          s    = v[mot];
          flip = cfg_i.motor_sign_mask[mot];
        end
        ops_d[k].mag        = twok_pkg::abs_mag(twok_pkg::sext_val(s));
        ops_d[k].neg        = s[twok_pkg::VAL_W-1] ^ flip;
        ops_d[k].coef       = cfg_i.rpm_to_velocity;
        ops_d[k].long_shift = 1'b0;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ops_q  <= ops_d;
      side_q <= side_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ops_o       = ops_q;
  assign side_o      = side_q;

endmodule

[design/twok_mul3.sv]
// three-lane magnitude multiplier: product stage, then round-to-nearest and sign stage
// depends on twok_pkg

module twok_mul3 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  twok_pkg::lane_ops_t ops_i,
  input  twok_pkg::side_t     side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output twok_pkg::res_vec_t  res_o,
  output twok_pkg::side_t     side_o
);

  logic                                       va_q, vb_q;
  logic                                       rdy_a, rdy_b;
  logic [twok_pkg::LANES-1:0][twok_pkg::PROD_W-1:0] prod_d, prod_q;
  logic [twok_pkg::LANES-1:0]                 neg_q, long_q;
  twok_pkg::side_t                            side_a_q, side_b_q;
  twok_pkg::res_vec_t                         res_d, res_q;
  logic [twok_pkg::PROD_W:0]                  half;
  logic [twok_pkg::PROD_W:0]                  rsum;
  logic [twok_pkg::PROD_W:0]                  shifted;

  always_comb begin
    for (int k = 0; k < twok_pkg::LANES; k++) begin
      prod_d[k] = ops_i[k].mag * ops_i[k].coef;
    end
  end

  // round half away from zero on the magnitude, then apply the sign
  always_comb begin
    res_d   = '0;
    half    = '0;
    rsum    = '0;
    shifted = '0;
    for (int k = 0; k < twok_pkg::LANES; k++) begin
      half                          = '0;
      half[twok_pkg::K_SHIFT-1]     = long_q[k];
      half[twok_pkg::FRAC_BITS-1]   = !long_q[k];
      rsum     = {1'b0, prod_q[k]} + half;
      shifted  = long_q[k] ? (rsum >> twok_pkg::K_SHIFT) : (rsum >> twok_pkg::FRAC_BITS);
      res_d[k] = neg_q[k] ? ({twok_pkg::RES_W{1'b0}} - {1'b0, shifted}) : {1'b0, shifted};
    end
  end

  assign rdy_b      = !vb_q || out_ready_i;
  assign rdy_a      = !va_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_a) begin
      prod_q   <= prod_d;
      side_a_q <= side_i;
      for (int k = 0; k < twok_pkg::LANES; k++) begin
        neg_q[k]  <= ops_i[k].neg;
        long_q[k] <= ops_i[k].long_shift;
      end
    end
    if (va_q && rdy_b) begin
      res_q    <= res_d;
      side_b_q <= side_a_q;
    end
  end

  assign out_valid_o = vb_q;
  assign res_o       = res_q;
  assign side_o      = side_b_q;

endmodule

[design/twok_mix.sv]
// layout matrix stage: clips first-layer results, forms wheel or body sums,
// and prepares second-layer operands; depends on twok_pkg

module twok_mix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  twok_pkg::res_vec_t  res_i,
  input  twok_pkg::side_t     side_i,
  input  twok_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output twok_pkg::lane_ops_t ops_o,
  output twok_pkg::side_t     side_o
);

  logic                                valid_q;
  twok_pkg::lane_ops_t                 ops_d, ops_q;
  twok_pkg::side_t                     side_d, side_q;
  twok_pkg::clip_t                     c;
  twok_pkg::clip_t                     cu;
  logic signed [twok_pkg::SUM_W-1:0]   t [twok_pkg::LANES];
  logic signed [twok_pkg::SUM_W-1:0]   sm [twok_pkg::LANES];
  logic signed [twok_pkg::SUM_W-1:0]   vy;
  logic [1:0]                          mot;
  logic                                flip;

  always_comb begin
    side_d = side_i;
    ops_d  = '0;
    c      = '0;
    cu     = '0;
    mot    = twok_pkg::MOTOR_NONE;
    flip   = 1'b0;
    vy     = twok_pkg::sext_val(side_i.vy);
    for (int k = 0; k < twok_pkg::LANES; k++) begin
      c          = twok_pkg::clip32($signed(res_i[k]));
      t[k]       = twok_pkg::sext_val(c.val);
      side_d.sat = side_d.sat | c.sat;
    end
    if (side_i.req == twok_pkg::REQ_INVERSE) begin
      // t0 = vx term, t1 = vy term, t2 = clipped rotation term
      if (cfg_i.layout_reversed) begin
        sm[0] = t[0] - t[1] + t[2];
        sm[1] = vy + t[2];
        sm[2] = -t[0] - t[1] + t[2];
      end else begin
        sm[0] = t[0] + t[1] + t[2];
        sm[1] = -t[0] + t[1] + t[2];
        sm[2] = -vy + t[2];
      end
      for (int k = 0; k < twok_pkg::LANES; k++) begin
        cu         = twok_pkg::clip32(twok_pkg::sext_sum(sm[k]));
        side_d.sat = side_d.sat | cu.sat;
        mot        = twok_pkg::slot_motor(cfg_i.motor_slot_map, k);
        flip       = 1'b0;
        if (mot != twok_pkg::MOTOR_NONE) begin
          flip = cfg_i.motor_sign_mask[mot];
        end
        ops_d[k].mag        = twok_pkg::abs_mag(twok_pkg::sext_val(cu.val));
        ops_d[k].neg        = cu.val[twok_pkg::VAL_W-1] ^ flip;
        ops_d[k].coef       = cfg_i.velocity_to_rpm;
        ops_d[k].long_shift = 1'b0;
      end
    end else begin
      if (cfg_i.layout_reversed) begin
        sm[0] = t[0] - t[2];
        sm[1] = -t[0] + t[1] + t[1] - t[2];
      end else begin
        sm[0] = t[0] - t[1];
        sm[1] = t[0] + t[1] - t[2] - t[2];
      end
      sm[2] = t[0] + t[1] + t[2];
      for (int k = 0; k < twok_pkg::LANES; k++) begin
        ops_d[k].mag = twok_pkg::abs_mag(sm[k]);
        ops_d[k].neg = sm[k][twok_pkg::SUM_W-1];
      end
      ops_d[0].coef       = twok_pkg::K_INV_SQRT3;
      ops_d[0].long_shift = 1'b1;
      ops_d[1].coef       = twok_pkg::K_INV3;
      ops_d[1].long_shift = 1'b1;
      ops_d[2].coef       = cfg_i.rotation_gain;
      ops_d[2].long_shift = 1'b0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ops_q  <= ops_d;
      side_q <= side_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ops_o       = ops_q;
  assign side_o      = side_q;

endmodule

[design/twok_back.sv]
// output stage: final clip, motor routing for inverse items, output register
// depends on twok_pkg

module twok_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  twok_pkg::res_vec_t             res_i,
  input  twok_pkg::side_t                side_i,
  input  twok_pkg::cfg_t                 cfg_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [twok_pkg::VAL_W-1:0] out_a_o,
  output logic signed [twok_pkg::VAL_W-1:0] out_b_o,
  output logic signed [twok_pkg::VAL_W-1:0] out_c_o,
  output logic                           saturated_o
);

  logic                              valid_q;
  logic signed [twok_pkg::VAL_W-1:0] val_d [twok_pkg::LANES];
  logic signed [twok_pkg::VAL_W-1:0] val_q [twok_pkg::LANES];
  logic                              sat_d, sat_q;
  twok_pkg::clip_t                   c;
  logic [1:0]                        mot;

  always_comb begin
    sat_d = side_i.sat;
    c     = '0;
    mot   = twok_pkg::MOTOR_NONE;
    for (int k = 0; k < twok_pkg::LANES; k++) begin
      val_d[k] = '0;
    end
    for (int k = 0; k < twok_pkg::LANES; k++) begin
      c = twok_pkg::clip32($signed(res_i[k]));
      if (side_i.req == twok_pkg::REQ_INVERSE) begin
        // later slots overwrite, so the highest slot naming a motor wins
        mot = twok_pkg::slot_motor(cfg_i.motor_slot_map, k);
        if (mot != twok_pkg::MOTOR_NONE) begin
          val_d[mot] = c.val;
          sat_d      = sat_d | c.sat;
        end
      end else begin
        val_d[k] = c.val;
        sat_d    = sat_d | c.sat;
      end
    end
  end

  assign in_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      val_q <= val_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_a_o     = val_q[0];
  assign out_b_o     = val_q[1];
  assign out_c_o     = val_q[2];
  assign saturated_o = sat_q;

endmodule

[design/three_wheel_omni_kinematics_core.sv]
// top level of the three-wheel omni kinematics core: configuration registers and pipeline
// depends on twok_pkg, twok_front, twok_mul3, twok_mix and twok_back

// Converts three motor speeds into body velocity (req_type 0) or body velocity into three
// motor speeds (req_type 1), all signed Q16.16 with saturation reported per item. One item
// is accepted every clock cycle while in_stall_o is low, and passes through the operand
// selection register, the product and then the rounding register of each of the two
// multiply layers, the register of the wheel-layout sums and then the output
// register. Stalls back up stage by stage, so empty stages keep filling while a result
// waits. Configuration is written through a separate always-ready port and is only to be
// changed while no item is in flight.

module three_wheel_omni_kinematics_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twok_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [twok_pkg::COEF_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_a_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_b_i,
  input  logic signed [twok_pkg::VAL_W-1:0] in_c_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [twok_pkg::VAL_W-1:0] out_a_o,
  output logic signed [twok_pkg::VAL_W-1:0] out_b_o,
  output logic signed [twok_pkg::VAL_W-1:0] out_c_o,
  output logic                              saturated_o
);

  twok_pkg::cfg_t      cfg_q;
  logic                front_ready, front_valid;
  logic                mul1_ready, mul1_valid;
  logic                mix_ready, mix_valid;
  logic                mul2_ready, mul2_valid;
  logic                back_ready;
  twok_pkg::lane_ops_t front_ops, mix_ops;
  twok_pkg::side_t     front_side, mul1_side, mix_side, mul2_side;
  twok_pkg::res_vec_t  mul1_res, mul2_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layout_reversed <= 1'b0;
      cfg_q.wheel_distance  <= 24'd13107;
      cfg_q.rotation_gain   <= 32'd109227;
      cfg_q.rpm_to_velocity <= 32'd65536;
      cfg_q.velocity_to_rpm <= 32'd65536;
      cfg_q.motor_slot_map  <= 6'd36;
      cfg_q.motor_sign_mask <= 3'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (twok_pkg::cfg_idx_e'(cfg_index_i))
        twok_pkg::CFG_LAYOUT:     cfg_q.layout_reversed <= cfg_data_i[0];
        twok_pkg::CFG_DISTANCE:   cfg_q.wheel_distance  <= cfg_data_i[twok_pkg::DIST_W-1:0];
        twok_pkg::CFG_ROT_GAIN:   cfg_q.rotation_gain   <= cfg_data_i;
        twok_pkg::CFG_RPM_TO_VEL: cfg_q.rpm_to_velocity <= cfg_data_i;
        twok_pkg::CFG_VEL_TO_RPM: cfg_q.velocity_to_rpm <= cfg_data_i;
        twok_pkg::CFG_SLOT_MAP:   cfg_q.motor_slot_map  <= cfg_data_i[twok_pkg::MAP_W-1:0];
        twok_pkg::CFG_SIGN_MASK:  cfg_q.motor_sign_mask <= cfg_data_i[twok_pkg::LANES-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = !front_ready;

  twok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .req_type_i  (req_type_i),
    .in_a_i      (in_a_i),
    .in_b_i      (in_b_i),
    .in_c_i      (in_c_i),
    .cfg_i       (cfg_q),
    .out_valid_o (front_valid),
    .out_ready_i (mul1_ready),
    .ops_o       (front_ops),
    .side_o      (front_side)
  );

  twok_mul3 u_mul1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (mul1_ready),
    .ops_i       (front_ops),
    .side_i      (front_side),
    .out_valid_o (mul1_valid),
    .out_ready_i (mix_ready),
    .res_o       (mul1_res),
    .side_o      (mul1_side)
  );

  twok_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul1_valid),
    .in_ready_o  (mix_ready),
    .res_i       (mul1_res),
    .side_i      (mul1_side),
    .cfg_i       (cfg_q),
    .out_valid_o (mix_valid),
    .out_ready_i (mul2_ready),
    .ops_o       (mix_ops),
    .side_o      (mix_side)
  );

  twok_mul3 u_mul2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (mul2_ready),
    .ops_i       (mix_ops),
    .side_i      (mix_side),
    .out_valid_o (mul2_valid),
    .out_ready_i (back_ready),
    .res_o       (mul2_res),
    .side_o      (mul2_side)
  );

  twok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul2_valid),
    .in_ready_o  (back_ready),
    .res_i       (mul2_res),
    .side_i      (mul2_side),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .saturated_o (saturated_o)
  );

endmodule

[design/twok_checker.sv]
// port-level checks for the three-wheel omni kinematics core, bound to the top level
// depends on twok_pkg and three_wheel_omni_kinematics_core

module twok_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [twok_pkg::IDX_W-1:0]        cfg_index_i,
  input logic [twok_pkg::COEF_W-1:0]       cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              req_type_i,
  input logic signed [twok_pkg::VAL_W-1:0] in_a_i,
  input logic signed [twok_pkg::VAL_W-1:0] in_b_i,
  input logic signed [twok_pkg::VAL_W-1:0] in_c_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [twok_pkg::VAL_W-1:0] out_a_o,
  input logic signed [twok_pkg::VAL_W-1:0] out_b_o,
  input logic signed [twok_pkg::VAL_W-1:0] out_c_o,
  input logic                              saturated_o
);

  // held item stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // held item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_a_o) && $stable(out_b_o) && $stable(out_c_o) && $stable(saturated_o))
    else $error("result item changed while stalled");

  // input only backs up when the whole pipeline is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // with a free-running output an accepted item reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind three_wheel_omni_kinematics_core twok_checker u_twok_checker (.*);
